// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/pqts_pkg.sv
// ---------------------------------------------------------------------------
// pqts_pkg
// Types and constants of the priority quantum task scheduler.
// ---------------------------------------------------------------------------
package pqts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int ID_W      = 10;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PRIO = 1'b1;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  localparam logic [TIME_W-1:0]        QUANTUM_RST    = 16'd5;
  localparam logic signed [PRIO_W-1:0] START_PRIO_RST = 8'sd5;
  localparam logic signed [PRIO_W-1:0] PRIO_FLOOR     = 8'sh80;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] exec_time;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] ran_time;
    logic              completed;
    logic              queue_empty;
    logic              rejected;
  } out_item_t;

  typedef struct packed {
    logic                     valid;
    logic [ID_W-1:0]          id;
    logic [TIME_W-1:0]        rem;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    entry_t   ins;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_REQUEUE
  } state_e;

endpackage

// File: sv/pqts_cell.sv
// ---------------------------------------------------------------------------
// pqts_cell
// One slot of the sorted task chain: keeps, takes the new task or takes a neighbor.
// ---------------------------------------------------------------------------
module pqts_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pqts_pkg::cell_cmd_t cmd_i,
  input  pqts_pkg::entry_t    left_i,
  input  logic                left_keep_i,
  input  pqts_pkg::entry_t    right_i,
  output pqts_pkg::entry_t    entry_o,
  output logic                keep_o
);
  import pqts_pkg::*;

  logic                     valid_q;
  logic [ID_W-1:0]          id_q;
  logic [TIME_W-1:0]        rem_q;
  logic signed [PRIO_W-1:0] prio_q;
  entry_t                   entry_d;

  assign entry_o = '{valid: valid_q, id: id_q, rem: rem_q, prio: prio_q};

  // A valid task at or ahead of the incoming priority stays where it is.
  assign keep_o = valid_q && (prio_q <= cmd_i.ins.prio);

  always_comb begin
    entry_d = entry_o;
    case (cmd_i.op)
      OP_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            entry_d = cmd_i.ins;
          end else begin
            entry_d = left_i;
          end
        end
      end
      OP_SHIFT: entry_d = right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= entry_d.id;
    rem_q  <= entry_d.rem;
    prio_q <= entry_d.prio;
  end

endmodule

// File: sv/priority_quantum_task_scheduler_core.sv
// ---------------------------------------------------------------------------
// priority_quantum_task_scheduler_core
// Sorted task table with quantum-based dispatch, built as a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
// Items come in on in_data_i with in_valid_i/in_stall_o; a transfer happens
// when valid is high and stall is low. Mode add enters a task at the
// configured start priority; mode dispatch runs the head task for one quantum.
// Every item produces exactly one result on out_data_o with out_valid_o and
// out_stall_i. The result is written to a two-entry output queue in the cycle
// of the input transfer and is registered there before it shows on the output.
// An add, a completing dispatch and a dispatch on an empty table finish with the
// transfer itself. A dispatch that requeues its task first shifts the head out
// of the chain and then, in the requeue state, inserts the requeued task,
// since each cell moves by one slot per cycle.
// Input is stalled while the requeue is done and while the output queue is
// full, so a stalled receiver lets up to two results wait before input stops.
// Reset empties the table and the output queue and loads quantum and start
// priority with 5. The user writes configuration through cfg_we_i, cfg_index_i
// and cfg_data_i only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module priority_quantum_task_scheduler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pqts_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pqts_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [pqts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pqts_pkg::CFG_W-1:0]          cfg_data_i
);
  import pqts_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0]        quantum_q;
  logic signed [PRIO_W-1:0] start_prio_q;

  // Control state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  entry_t           requeue_q;

  // Chain of cells.
  cell_cmd_t              cmd;
  entry_t                 entries [MAX_TASKS];
  logic [MAX_TASKS-1:0]   keeps;

  // Output queue of two results.
  out_item_t fifo_q [2];
  logic      wr_ptr_q, rd_ptr_q;
  logic [1:0] fifo_cnt_q;

  logic      in_xfer, out_xfer;
  logic      table_full, table_empty;
  logic      head_over;
  logic      needs_requeue;
  out_item_t result;
  entry_t    requeue_d;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign table_full  = (count_q == CNT_W'(MAX_TASKS));
  assign table_empty = (count_q == '0);
  assign head_over   = (entries[0].rem > quantum_q);

  // A dispatch of a task with more time left than one quantum goes back in.
  assign needs_requeue = in_xfer && (in_data_i.mode == MODE_DISPATCH) &&
                         !table_empty && head_over;

  assign in_stall_o  = (state_q != ST_IDLE) || (fifo_cnt_q == 2'd2);
  assign out_valid_o = (fifo_cnt_q != 2'd0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  // The requeued task carries its reduced time and a priority one step ahead,
  // held at the floor.
  always_comb begin
    requeue_d       = entries[0];
    requeue_d.valid = 1'b1;
    requeue_d.rem   = entries[0].rem - quantum_q;
    if (entries[0].prio != PRIO_FLOOR) begin
      requeue_d.prio = entries[0].prio - PRIO_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (needs_requeue) begin
          state_d = ST_REQUEUE;
        end
      end
      ST_REQUEUE: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller: the chain command and the result of the item.
  always_comb begin
    cmd.op  = OP_HOLD;
    cmd.ins = '{valid: 1'b1, id: in_data_i.task_id, rem: in_data_i.exec_time,
                prio: start_prio_q};
    result  = '0;
    unique case (state_q)
      ST_REQUEUE: begin
        cmd.op  = OP_INSERT;
        cmd.ins = requeue_q;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.mode == MODE_ADD) begin
            if (table_full) begin
              result.rejected = 1'b1;
            end else begin
              cmd.op = OP_INSERT;
            end
          end else if (table_empty) begin
            result.queue_empty = 1'b1;
          end else begin
            cmd.op         = OP_SHIFT;
            result.done_id = entries[0].id;
            if (head_over) begin
              result.ran_time = quantum_q;
            end else begin
              result.ran_time  = entries[0].rem;
              result.completed = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    case (cmd.op)
      OP_INSERT: count_d = count_q + CNT_W'(1);
      OP_SHIFT:  count_d = count_q - CNT_W'(1);
      default: ;
    endcase
  end

  // Cell 0 sees an always-keeping left edge; the last cell shifts in an empty slot.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_keep;

    if (i == 0) begin : g_first
      assign left_e    = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_e    = entries[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    pqts_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_e),
      .left_keep_i (left_keep),
      .right_i     (right_e),
      .entry_o     (entries[i]),
      .keep_o      (keeps[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      quantum_q    <= QUANTUM_RST;
      start_prio_q <= START_PRIO_RST;
      wr_ptr_q     <= 1'b0;
      rd_ptr_q     <= 1'b0;
      fifo_cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_QUANTUM:    quantum_q    <= cfg_data_i;
          CFG_START_PRIO: start_prio_q <= cfg_data_i[PRIO_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_xfer) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (in_xfer && !out_xfer) begin
        fifo_cnt_q <= fifo_cnt_q + 2'd1;
      end else if (!in_xfer && out_xfer) begin
        fifo_cnt_q <= fifo_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fifo_q[wr_ptr_q] <= result;
    end
    if (needs_requeue) begin
      requeue_q <= requeue_d;
    end
  end

endmodule

// File: sv/pqts_checker.sv
// ---------------------------------------------------------------------------
// pqts_checker
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pqts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pqts_pkg::out_item_t out_data_o
);
  import pqts_pkg::*;

  logic       in_xfer, out_xfer;
  logic       out_held;
  logic       empty_fields_zero;
  logic [2:0] pending_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign out_held = out_valid_o && out_stall_i;

  // A dispatch that found no task reports nothing else.
  assign empty_fields_zero = (out_data_o.done_id == '0) && (out_data_o.ran_time == '0) &&
                             !out_data_o.completed && !out_data_o.rejected;

  // Items taken in whose results have not yet been handed out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))
  `ASSERT_IMP(a_no_invented, clk_i, rst_ni, out_valid_o, pending_q != 3'd0)
  `ASSERT_IMP(a_pending_bound, clk_i, rst_ni, 1'b1, pending_q <= 3'd2)
  `ASSERT_IMP(a_empty_clean, clk_i, rst_ni, out_valid_o && out_data_o.queue_empty, empty_fields_zero)

endmodule

bind priority_quantum_task_scheduler_core pqts_checker u_pqts_checker (.*);

// File: tb/sv/task_schedule_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// task_schedule_checker
// Watches both channels and the register port of the task scheduler, keeps
// its own copy of the sorted task table, predicts the result of every input
// transfer and compares each output transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module task_schedule_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pqts_pkg::in_item_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pqts_pkg::out_item_t            out_data_i,
  input  logic                           cfg_we_i,
  input  logic [pqts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pqts_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             mismatch_count_o,
  output int                             outstanding_o
);
  import pqts_pkg::*;

  logic [ID_W-1:0]          slot_id   [MAX_TASKS];
  logic [TIME_W-1:0]        slot_rem  [MAX_TASKS];
  logic signed [PRIO_W-1:0] slot_prio [MAX_TASKS];
  int                       occupied   = 0;
  logic [TIME_W-1:0]        quantum    = QUANTUM_RST;
  logic signed [PRIO_W-1:0] start_prio = START_PRIO_RST;
  out_item_t                awaited_results[$];
  int                       mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // A task goes behind every entry whose priority value is not larger.
  task automatic insert_task(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] rem,
                             input logic signed [PRIO_W-1:0] prio);
    int pos;
    pos = 0;
    while (pos < occupied && slot_prio[pos] <= prio) pos++;
    for (int k = occupied; k > pos; k--) begin
      slot_id[k]   = slot_id[k-1];
      slot_rem[k]  = slot_rem[k-1];
      slot_prio[k] = slot_prio[k-1];
    end
    slot_id[pos]   = id;
    slot_rem[pos]  = rem;
    slot_prio[pos] = prio;
    occupied++;
  endtask

  task automatic schedule_item(input in_item_t item, output out_item_t res);
    logic [ID_W-1:0]          id;
    logic [TIME_W-1:0]        rem;
    logic signed [PRIO_W-1:0] prio;
    res = '0;
    if (item.mode == MODE_ADD) begin
      if (occupied >= MAX_TASKS) res.rejected = 1'b1;
      else insert_task(item.task_id, item.exec_time, start_prio);
    end else if (occupied == 0) begin
      res.queue_empty = 1'b1;
    end else begin
      id   = slot_id[0];
      rem  = slot_rem[0];
      prio = slot_prio[0];
      for (int k = 0; k + 1 < occupied; k++) begin
        slot_id[k]   = slot_id[k+1];
        slot_rem[k]  = slot_rem[k+1];
        slot_prio[k] = slot_prio[k+1];
      end
      occupied--;
      res.done_id = id;
      if (rem > quantum) begin
        res.ran_time = quantum;
        if (prio != PRIO_FLOOR) prio = prio - 8'sd1;
        insert_task(id, rem - quantum, prio);
      end else begin
        res.ran_time  = rem;
        res.completed = 1'b1;
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    string     wrong;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with done_id %0d arrived with nothing awaited",
                                got.done_id));
      return;
    end
    want  = awaited_results.pop_front();
    wrong = "";
    if (got.done_id !== want.done_id)
      wrong = {wrong, $sformatf(" done_id %0d/%0d", got.done_id, want.done_id)};
    if (got.ran_time !== want.ran_time)
      wrong = {wrong, $sformatf(" ran_time %0d/%0d", got.ran_time, want.ran_time)};
    if (got.completed !== want.completed)
      wrong = {wrong, $sformatf(" completed %b/%b", got.completed, want.completed)};
    if (got.queue_empty !== want.queue_empty)
      wrong = {wrong, $sformatf(" queue_empty %b/%b", got.queue_empty, want.queue_empty)};
    if (got.rejected !== want.rejected)
      wrong = {wrong, $sformatf(" rejected %b/%b", got.rejected, want.rejected)};
    if (wrong != "") report_mismatch({"got/expected:", wrong});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t predicted;
    if (!rst_ni) begin
      occupied   = 0;
      quantum    = QUANTUM_RST;
      start_prio = START_PRIO_RST;
      awaited_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        schedule_item(in_data_i, predicted);
        awaited_results.push_back(predicted);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_QUANTUM) quantum = cfg_data_i[TIME_W-1:0];
        else if (cfg_index_i == CFG_START_PRIO) start_prio = cfg_data_i[PRIO_W-1:0];
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= awaited_results.size();
  end

endmodule

// File: tb/sv/tb_priority_quantum_task_scheduler_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_priority_quantum_task_scheduler_core
// Drives add and dispatch items into the task scheduler under several
// quantum and start priority settings, with random gaps on both channels,
// and leaves prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module tb_priority_quantum_task_scheduler_core;
  import pqts_pkg::*;

  // Cycles without any transfer before the run is declared hung. The slowest
  // correct stretch is a drain plus a register write.
  localparam int IDLE_LIMIT  = 4000;
  // Extra cycles after the last result so a requeue insert can finish.
  localparam int SETTLE_GAP  = 4;
  // Items per random segment; twelve segments give about 1300 items.
  localparam int SEGMENT_LEN = 108;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_QUANTUM;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int mismatch_count;
  int outstanding;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int cur_quantum  = int'(QUANTUM_RST);
  int quiet_cycles = 0;

  priority_quantum_task_scheduler_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  task_schedule_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, at the rate of the current idling phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one item, after a random number of idle cycles, and returns at the
  // edge where its transfer takes place. Stall is sampled before the edge's
  // updates land, so the check sees the same value the block saw.
  task automatic send_item(input logic mode, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {mode, id, t};
    do @(posedge clk); while (in_stall);
  endtask

  // Dispatch items carry random id and run time, which the block must ignore.
  task automatic dispatch_head();
    send_item(MODE_DISPATCH, ID_W'($urandom_range(0, 1023)),
              TIME_W'($urandom_range(0, 65535)));
  endtask

  // Holds the sender back until every predicted result has been seen, then
  // waits out SETTLE_GAP so that a requeue in flight can land in the table.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Registers are only written while the block is idle. The write enable
  // stays high across both writes so it is never lowered and raised in one step.
  task automatic apply_setting(input logic [TIME_W-1:0] q, input logic signed [PRIO_W-1:0] p);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUANTUM;
    cfg_data  <= q;
    @(posedge clk);
    cfg_index <= CFG_START_PRIO;
    cfg_data  <= {{(CFG_W-PRIO_W){p[PRIO_W-1]}}, p};
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_quantum = int'(q);
  endtask

  // Mostly run times of a few quanta, so tasks requeue a handful of times and
  // bubble forward as they gain priority; now and then any length at all.
  function automatic logic [TIME_W-1:0] pick_exec();
    int span;
    int roll;
    span = cur_quantum * 4;
    if (span > 65535) span = 65535;
    roll = $urandom_range(0, 9);
    if (roll < 7) return TIME_W'($urandom_range(1, span));
    if (roll < 9) return TIME_W'($urandom_range(1, 65535));
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
  endfunction

  // Settings lean toward the extremes: a quantum of one or of the full range,
  // and start priorities at the floor or the ceiling.
  task automatic pick_setting();
    logic [TIME_W-1:0]        q;
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(0, 4))
      0: q = 16'd1;
      1: q = 16'hFFFF;
      2: q = TIME_W'($urandom_range(1, 8));
      3: q = TIME_W'($urandom_range(1, 300));
      default: q = TIME_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: p = PRIO_FLOOR;
      1: p = 8'sd127;
      2: begin
        p = PRIO_W'($urandom_range(0, 8));
        p = p - 8'sd4;
      end
      default: p = PRIO_W'($urandom_range(0, 255));
    endcase
    apply_setting(q, p);
  endtask

  // Random traffic in bursts: an add-heavy burst can fill the table up to
  // rejection, a dispatch-heavy one can drain it down to empty dispatches.
  task automatic run_segment(input int n_items);
    int left;
    int burst;
    bit adding;
    left = n_items;
    while (left > 0) begin
      adding = 1'($urandom_range(0, 1));
      burst  = $urandom_range(1, 20);
      for (int b = 0; b < burst && left > 0; b++) begin
        if (($urandom_range(0, 99) < 85) == adding) begin
          send_item(MODE_ADD, ID_W'($urandom_range(0, 1023)), pick_exec());
        end else begin
          dispatch_head();
        end
        left--;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct <= 34;
    rx_idle_pct <= 45;
    @(posedge clk);

    // Reset settings: quantum 5, start priority 5. A dispatch on the empty
    // table first, then tasks that finish early, finish with zero run time,
    // finish exactly on the quantum, and overrun it by one.
    dispatch_head();
    send_item(MODE_ADD, 10'd0,   16'd1);
    send_item(MODE_ADD, 10'd341, 16'd0);
    send_item(MODE_ADD, 10'd682, 16'd5);
    send_item(MODE_ADD, 10'd7,   16'd6);
    send_item(MODE_ADD, 10'd1023, 16'hFFFF);
    repeat (4) dispatch_head();

    // Full quantum with the lowest start priority: the new task jumps ahead
    // and completes in one turn with the largest run time.
    apply_setting(16'hFFFF, PRIO_FLOOR);
    send_item(MODE_ADD, 10'd5, 16'hFFFF);
    repeat (2) dispatch_head();

    // A task at the priority floor stays there while it is requeued.
    apply_setting(16'd1, PRIO_FLOOR);
    send_item(MODE_ADD, 10'd9, 16'd3);
    repeat (2) dispatch_head();

    // A zero quantum runs the head for nothing and still requeues it.
    apply_setting(16'd0, 8'sd127);
    send_item(MODE_ADD, 10'd3, 16'd2);
    repeat (2) dispatch_head();

    // Random part in three idling phases: receiver-heavy gaps, sender-heavy
    // gaps, then back-to-back transfers. Every segment starts from a drained
    // block with a fresh setting.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct <= 34;
          rx_idle_pct <= 45;
        end
        1: begin
          tx_idle_pct <= 45;
          rx_idle_pct <= 34;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        pick_setting();
        run_segment(SEGMENT_LEN);
      end
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
